/* hdl/lst_pkg.sv */
// Shared types and constants for the latency statistics tracker.
`default_nettype none
package lst_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int ADDR_W       = 3;
  localparam int RATE_W       = 10;
  localparam int STAT_W       = 32;
  localparam int AVG_SHIFT    = 4;

  localparam logic [RATE_W-1:0] RATE_RESET  = 10'd216;
  localparam logic [STAT_W-1:0] LIMIT_RESET = 32'd1000;
  localparam logic [STAT_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;

  // Register index, taken from paddr[2]
  localparam logic REG_RATE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // Input item modes
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // One channel's statistics, as stored and as returned
  typedef struct packed {
    logic [STAT_W-1:0] last_us;
    logic [STAT_W-1:0] min_us;
    logic [STAT_W-1:0] max_us;
    logic [STAT_W-1:0] avg_us;
    logic [STAT_W-1:0] sample_count;
    logic [STAT_W-1:0] slow_count;
  } stats_t;

  localparam stats_t STATS_CLEAR = '{
    last_us:      '0,
    min_us:       ALL_ONES,
    max_us:       '0,
    avg_us:       '0,
    sample_count: '0,
    slow_count:   '0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_UPD
  } state_t;

endpackage
`default_nettype wire

/* hdl/latency_stats_tracker_top.sv */
// Latency statistics tracker: per-channel last/min/max/average/count statistics.
`default_nettype none
// A bank of CHANNELS statistics channels held in one synchronous memory
// (one word per channel, registered read). Each input transfer either
// records a cycle count on a channel or clears it; every transfer on a
// channel inside the bank returns one result with that channel's updated
// statistics, and a transfer on a channel beyond the bank is dropped. A
// record passes through the idle state that accepts the transfer, one memory
// read state, the bit-serial divider that converts cycles to microseconds
// (one quotient bit per cycle), and one read-modify-write state; the next
// transfer is accepted only after that. A clear skips the divider. If the
// previous result has not been taken yet, the write-back cycle waits for it.
// Channel entries read as cleared after reset through per-entry valid
// flops, so no clearing pass is needed.
module latency_stats_tracker_top
  import lst_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire  logic              clk,
  input  wire  logic              rst,
  // input channel
  input  wire  logic              in_valid,
  output logic                    in_stall,
  input  wire  logic              mode,
  input  wire  logic [1:0]        channel,
  input  wire  logic [STAT_W-1:0] cycles,
  // result channel
  output logic                    out_valid,
  input  wire  logic              out_stall,
  output logic [STAT_W-1:0]       last_us,
  output logic [STAT_W-1:0]       min_us,
  output logic [STAT_W-1:0]       max_us,
  output logic [STAT_W-1:0]       avg_us,
  output logic [STAT_W-1:0]       sample_count,
  output logic [STAT_W-1:0]       slow_count,
  // configuration port
  input  wire  logic              psel,
  input  wire  logic              penable,
  input  wire  logic              pwrite,
  input  wire  logic [ADDR_W-1:0] paddr,
  input  wire  logic [31:0]       pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(STAT_W);

  // Configuration registers
  logic [RATE_W-1:0] rate;
  logic [STAT_W-1:0] limit;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate  <= RATE_RESET;
      limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RATE:  rate  <= pwdata[RATE_W-1:0];
        REG_LIMIT: limit <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RATE:  prdata = {{(32-RATE_W){1'b0}}, rate};
      REG_LIMIT: prdata = limit;
      default:   prdata = '0;
    endcase
  end

  // Control registers
  state_t              state, state_next;
  logic                mode_q;
  logic [CH_W-1:0]     ch_q;
  logic [CH_W+1:0]     ch_wide;
  logic                ch_in_range;
  logic [CNT_W-1:0]    cnt;
  logic [CHANNELS-1:0] ent_ok;
  logic                ent_ok_q;
  logic                accept, upd_go;

  assign ch_wide     = {{CH_W{1'b0}}, channel};
  assign ch_in_range = (32'(channel) < 32'(CHANNELS));
  assign accept      = in_valid && !in_stall;

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    upd_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && ch_in_range) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = (mode_q == MODE_CLEAR) ? ST_UPD : ST_DIV;
      end
      ST_DIV: begin
        if (cnt == '0) state_next = ST_UPD;
      end
      ST_UPD: begin
        upd_go = !out_valid || !out_stall;
        if (upd_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Statistics memory, one packed word per channel
  stats_t mem [CHANNELS];
  stats_t rd_q;
  stats_t ent;
  stats_t upd;

  always_ff @(posedge clk) begin
    if (state == ST_READ) rd_q <= mem[ch_q];
    if (upd_go)           mem[ch_q] <= upd;
  end

  // Entry valid bits: an entry not yet written reads as cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_ok <= '0;
    end else if (upd_go) begin
      ent_ok[ch_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) ent_ok_q <= ent_ok[ch_q];
  end

  assign ent = ent_ok_q ? rd_q : STATS_CLEAR;

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      ch_q   <= ch_wide[CH_W-1:0];
    end
  end

  // Bit-serial restoring divider: cycles / rate, one quotient bit per cycle
  logic [STAT_W-1:0] quo;
  logic [RATE_W-1:0] rem;
  logic [RATE_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[STAT_W-1]};
  assign fits  = (trial >= {1'b0, rate});

  always_ff @(posedge clk) begin
    if (accept) begin
      quo <= cycles;
      rem <= '0;
      cnt <= CNT_W'(STAT_W - 1);
    end else if (state == ST_DIV) begin
      quo <= {quo[STAT_W-2:0], fits};
      rem <= fits ? RATE_W'(trial - {1'b0, rate}) : trial[RATE_W-1:0];
      cnt <= cnt - 1'b1;
    end
  end

  // Statistics update
  logic signed [STAT_W:0] diff, diff_adj, step, avg_new;
  logic [STAT_W-1:0]      us;

  assign us       = quo;
  assign diff     = $signed({1'b0, us}) - $signed({1'b0, ent.avg_us});
  // bias negative differences so the shift truncates toward zero
  assign diff_adj = diff[STAT_W] ? diff + (STAT_W+1)'((1 << AVG_SHIFT) - 1) : diff;
  assign step     = diff_adj >>> AVG_SHIFT;
  assign avg_new  = $signed({1'b0, ent.avg_us}) + step;

  always_comb begin
    if (mode_q == MODE_CLEAR) begin
      upd = STATS_CLEAR;
    end else begin
      upd.last_us      = us;
      upd.min_us       = (us < ent.min_us) ? us : ent.min_us;
      upd.max_us       = (us > ent.max_us) ? us : ent.max_us;
      upd.slow_count   = (us > limit) ? ent.slow_count + 1'b1 : ent.slow_count;
      upd.avg_us       = (ent.sample_count == '0) ? us : avg_new[STAT_W-1:0];
      upd.sample_count = ent.sample_count + 1'b1;
    end
  end

  // Result register
  stats_t out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) out_q <= upd;
  end

  assign last_us      = out_q.last_us;
  assign min_us       = out_q.min_us;
  assign max_us       = out_q.max_us;
  assign avg_us       = out_q.avg_us;
  assign sample_count = out_q.sample_count;
  assign slow_count   = out_q.slow_count;

endmodule
`default_nettype wire
